/* sv/morus1280_encrypt_step_core_macros.svh */
// Assertion macros shared by the MORUS-1280 encrypt step checker.
`ifndef MORUS1280_ENCRYPT_STEP_CORE_MACROS_SVH
`define MORUS1280_ENCRYPT_STEP_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define MORUS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define MORUS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/morus_pkg.sv */
// Types, constants and round functions for the MORUS-1280 encrypt step core.
package morus_pkg;

  localparam int ROWS      = 5;
  localparam int LANES     = 4;
  localparam int WORD_W    = 64;
  localparam int RESULTS   = ROWS + 1;
  localparam int ROW_IDX_W = 3;
  localparam int CNT_W     = 3;

  localparam int unsigned ROT0 = 13;
  localparam int unsigned ROT1 = 46;
  localparam int unsigned ROT2 = 38;
  localparam int unsigned ROT3 = 7;
  localparam int unsigned ROT4 = 4;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [LANES-1:0][WORD_W-1:0] row_t;

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_ENCRYPT = 1'b1
  } opcode_t;

  typedef enum logic {
    KIND_CIPHER = 1'b0,
    KIND_ROW    = 1'b1
  } kind_t;

  typedef struct packed {
    opcode_t              opcode;
    logic [ROW_IDX_W-1:0] row_select;
    row_t                 data;
  } item_t;

  typedef struct packed {
    kind_t                kind;
    logic [ROW_IDX_W-1:0] row;
    row_t                 data;
    logic                 last;
  } result_t;

  typedef result_t [RESULTS-1:0] burst_t;

  function automatic word_t lane_rotl(input word_t x, input int unsigned n);
    return (x << n) | (x >> (WORD_W - n));
  endfunction

  // Whole-lane rotation: lane i takes lane (i - k) mod 4.
  function automatic row_t row_rotw(input row_t r, input logic [1:0] k);
    row_t       t;
    logic [1:0] src;
    for (int i = 0; i < LANES; i++) begin
      src  = 2'(i) - k;
      t[i] = r[src];
    end
    return t;
  endfunction

  function automatic row_t round_mix(input row_t a, input row_t b, input row_t c,
                                     input row_t d, input row_t m,
                                     input int unsigned n);
    row_t t;
    for (int i = 0; i < LANES; i++) begin
      t[i] = lane_rotl(a[i] ^ b[i] ^ (c[i] & d[i]) ^ m[i], n);
    end
    return t;
  endfunction

endpackage

/* sv/morus_in_stage.sv */
// Input register stage that holds one accepted item until the state core takes it.
module morus_in_stage (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [3:0]            in_tuser,
  input  logic [255:0]          in_tdata,
  input  logic                  item_take,
  output logic                  item_valid,
  output morus_pkg::item_t      item
);

  logic             valid_r;
  logic             valid_nxt;
  morus_pkg::item_t item_r;
  logic             accept;

  assign in_tready  = !valid_r || item_take;
  assign accept     = in_tvalid && in_tready;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (item_take) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.opcode     <= morus_pkg::opcode_t'(in_tuser[0]);
      item_r.row_select <= in_tuser[3:1];
      item_r.data       <= in_tdata;
    end
  end

endmodule

/* sv/morus_state_core.sv */
// State rows, keystream and five-round update; encrypts wait on emit_free.
module morus_state_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_valid,
  input  morus_pkg::item_t  item,
  input  logic              emit_free,
  output logic              item_take,
  output logic              burst_load,
  output morus_pkg::burst_t burst
);

  morus_pkg::row_t state_r   [morus_pkg::ROWS];
  morus_pkg::row_t state_nxt [morus_pkg::ROWS];
  morus_pkg::row_t upd       [morus_pkg::ROWS];
  morus_pkg::row_t cipher;
  morus_pkg::row_t r1_s0, r1_s3, r2_s1, r2_s4, r3_s2, r3_s0, r4_s3, r4_s1, r5_s4, r5_s2;
  logic            is_load;

  assign is_load    = (item.opcode == morus_pkg::OP_LOAD);
  assign item_take  = item_valid && (is_load || emit_free);
  assign burst_load = item_valid && !is_load && emit_free;

  assign cipher = item.data ^ state_r[0] ^ morus_pkg::row_rotw(state_r[1], 2'd3)
                  ^ (state_r[2] & state_r[3]);

  assign r1_s0 = morus_pkg::round_mix(state_r[0], state_r[3], state_r[1], state_r[2],
                                      '0, morus_pkg::ROT0);
  assign r1_s3 = morus_pkg::row_rotw(state_r[3], 2'd1);
  assign r2_s1 = morus_pkg::round_mix(state_r[1], state_r[4], state_r[2], r1_s3,
                                      item.data, morus_pkg::ROT1);
  assign r2_s4 = morus_pkg::row_rotw(state_r[4], 2'd2);
  assign r3_s2 = morus_pkg::round_mix(state_r[2], r1_s0, r1_s3, r2_s4,
                                      item.data, morus_pkg::ROT2);
  assign r3_s0 = morus_pkg::row_rotw(r1_s0, 2'd3);
  assign r4_s3 = morus_pkg::round_mix(r1_s3, r2_s1, r2_s4, r3_s0,
                                      item.data, morus_pkg::ROT3);
  assign r4_s1 = morus_pkg::row_rotw(r2_s1, 2'd2);
  assign r5_s4 = morus_pkg::round_mix(r2_s4, r3_s2, r3_s0, r4_s1,
                                      item.data, morus_pkg::ROT4);
  assign r5_s2 = morus_pkg::row_rotw(r3_s2, 2'd1);

  assign upd[0] = r3_s0;
  assign upd[1] = r4_s1;
  assign upd[2] = r5_s2;
  assign upd[3] = r4_s3;
  assign upd[4] = r5_s4;

  always_comb begin
    for (int r = 0; r < morus_pkg::ROWS; r++) begin
      state_nxt[r] = state_r[r];
      if (item_take && is_load && (item.row_select == morus_pkg::ROW_IDX_W'(r))) begin
        state_nxt[r] = item.data;
      end else if (burst_load) begin
        state_nxt[r] = upd[r];
      end
    end
  end

  always_comb begin
    burst[0].kind = morus_pkg::KIND_CIPHER;
    burst[0].row  = '0;
    burst[0].data = cipher;
    burst[0].last = 1'b0;
    for (int r = 0; r < morus_pkg::ROWS; r++) begin
      burst[r+1].kind = morus_pkg::KIND_ROW;
      burst[r+1].row  = morus_pkg::ROW_IDX_W'(r);
      burst[r+1].data = upd[r];
      burst[r+1].last = (r == morus_pkg::ROWS - 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < morus_pkg::ROWS; r++) begin
        state_r[r] <= '0;
      end
    end else begin
      for (int r = 0; r < morus_pkg::ROWS; r++) begin
        state_r[r] <= state_nxt[r];
      end
    end
  end

endmodule

/* sv/morus_emit.sv */
// Result buffer that presents the six results of an encrypt item one per transfer.
module morus_emit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              burst_load,
  input  morus_pkg::burst_t burst,
  output logic              emit_free,
  output logic              out_tvalid,
  input  logic              out_tready,
  output morus_pkg::result_t head
);

  morus_pkg::burst_t              buf_r;
  morus_pkg::burst_t              buf_nxt;
  logic [morus_pkg::CNT_W-1:0]    cnt_r;
  logic [morus_pkg::CNT_W-1:0]    cnt_nxt;
  logic                           take;

  assign out_tvalid = (cnt_r != '0);
  assign take       = out_tvalid && out_tready;
  assign emit_free  = (cnt_r == '0) || ((cnt_r == morus_pkg::CNT_W'(1)) && out_tready);
  assign head       = buf_r[0];

  always_comb begin
    buf_nxt = buf_r;
    cnt_nxt = cnt_r;
    if (burst_load) begin
      buf_nxt = burst;
      cnt_nxt = morus_pkg::CNT_W'(morus_pkg::RESULTS);
    end else if (take) begin
      for (int i = 0; i < morus_pkg::RESULTS - 1; i++) begin
        buf_nxt[i] = buf_r[i+1];
      end
      cnt_nxt = cnt_r - morus_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
  end

endmodule

/* sv/morus1280_encrypt_step_core.sv */
// Top level of the MORUS-1280 encrypt step core.
// The core keeps the five 256-bit state rows and takes load and encrypt transfers. A load
// writes one row and returns nothing; a load to a row above 4 is dropped. An encrypt
// transfer returns six results: the ciphertext, then state rows 0 to 4, the last one with
// tlast set. The keystream and the whole five-round update are computed combinationally
// from the input register and the state rows and are registered in the result buffer; an
// encrypt item waits in the input register until that buffer is free. The output side
// moves one result per cycle while out_tready is high, and the next encrypt item enters
// the buffer as the last result of the one before is taken. Loads need no output side.
module morus1280_encrypt_step_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [255:0] in_tdata,   // in_word0, in_word1, in_word2, in_word3
  input  logic [3:0]   in_tuser,   // opcode, row_select
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [255:0] out_tdata,  // out_word0, out_word1, out_word2, out_word3
  output logic [3:0]   out_tuser,  // result_kind, result_row
  output logic         out_tlast
);

  logic               item_valid;
  morus_pkg::item_t   item;
  logic               item_take;
  logic               emit_free;
  logic               burst_load;
  morus_pkg::burst_t  burst;
  morus_pkg::result_t head;

  morus_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .item_take  (item_take),
    .item_valid (item_valid),
    .item       (item)
  );

  morus_state_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .emit_free  (emit_free),
    .item_take  (item_take),
    .burst_load (burst_load),
    .burst      (burst)
  );

  morus_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .burst_load (burst_load),
    .burst      (burst),
    .emit_free  (emit_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .head       (head)
  );

  assign out_tdata = head.data;
  assign out_tuser = {head.row, head.kind};
  assign out_tlast = head.last;

endmodule

/* sv/morus_checker.sv */
// Port-level checker for the MORUS-1280 encrypt step core and its bind statement.
`include "morus1280_encrypt_step_core_macros.svh"

module morus_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [255:0] out_tdata,
  input logic [3:0]   out_tuser,
  input logic         out_tlast
);

  logic is_cipher;
  logic out_xfer;

  assign is_cipher = (out_tuser[0] == morus_pkg::KIND_CIPHER);
  assign out_xfer  = out_tvalid && out_tready;

  `MORUS_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast),
    "Stalled result changed.")
  `MORUS_ASSERT_NOW(a_cipher_fields, out_tvalid && is_cipher,
    (out_tuser[3:1] == 3'd0) && !out_tlast, "Ciphertext result has bad row or tlast.")
  `MORUS_ASSERT_NOW(a_row_last, out_tvalid && !is_cipher,
    out_tlast == (out_tuser[3:1] == 3'd4), "tlast does not mark row 4.")
  `MORUS_ASSERT_NEXT(a_row0_follows, out_xfer && is_cipher,
    out_tvalid && !is_cipher && (out_tuser[3:1] == 3'd0),
    "Row 0 does not follow the ciphertext.")

endmodule

bind morus1280_encrypt_step_core morus_checker u_chk (.*);
